// File: design/ctc_pkg.sv
`default_nettype none
package ctc_pkg;

  localparam int FRAC_BITS    = 16;
  localparam int COORD_W      = 32;
  localparam int DIFF_W       = COORD_W + 1;
  localparam int CORDIC_STEPS = 28;
  localparam int ANG_XW       = 45;
  localparam int THETA_W      = 34;
  localparam int NORM_TOP     = 41;
  localparam int NORM_STAGES  = 3;
  localparam int DIV_NUM_W    = COORD_W + FRAC_BITS;
  localparam int PIPE_DEPTH   = 1 + DIV_NUM_W;
  localparam int ANG_DEPTH    = 1 + NORM_STAGES + CORDIC_STEPS;
  localparam int ANG_DELAY    = PIPE_DEPTH - ANG_DEPTH;
  localparam int LANES        = 3;
  localparam int VERT_W       = 3 * COORD_W;

  localparam logic [2:0] REG_AXIS   = 3'd0;
  localparam logic [2:0] REG_HMIN   = 3'd1;
  localparam logic [2:0] REG_HMAX   = 3'd2;
  localparam logic [2:0] REG_CFIRST = 3'd3;
  localparam logic [2:0] REG_CSECND = 3'd4;

  localparam logic [1:0] AXIS_X = 2'd1;
  localparam logic [1:0] AXIS_Y = 2'd2;
  localparam logic [1:0] AXIS_Z = 2'd3;

  localparam logic signed [THETA_W-1:0] TURN_HALF    = 34'sh0_8000_0000;
  localparam logic signed [THETA_W-1:0] TURN_QUARTER = 34'sh0_4000_0000;
  localparam logic signed [THETA_W:0]   TURN_FULL    = 35'sh1_0000_0000;

  localparam logic signed [DIFF_W-1:0] U_ONE  = DIFF_W'(1) <<< FRAC_BITS;
  localparam logic signed [DIFF_W-1:0] U_HALF = DIFF_W'(1) <<< (FRAC_BITS - 1);

  typedef struct packed {
    logic signed [COORD_W-1:0] hmin;
    logic [COORD_W-1:0]        span_mag;
    logic                      span_neg;
  } ctc_div_cfg_t;

  function automatic logic [29:0] atan_turn(input int idx);
    logic [29:0] r;
    case (idx)
      0:  r = 30'd536870912;
      1:  r = 30'd316933406;
      2:  r = 30'd167458907;
      3:  r = 30'd85004756;
      4:  r = 30'd42667331;
      5:  r = 30'd21354465;
      6:  r = 30'd10679838;
      7:  r = 30'd5340245;
      8:  r = 30'd2670163;
      9:  r = 30'd1335087;
      10: r = 30'd667544;
      11: r = 30'd333772;
      12: r = 30'd166886;
      13: r = 30'd83443;
      14: r = 30'd41722;
      15: r = 30'd20861;
      16: r = 30'd10430;
      17: r = 30'd5215;
      18: r = 30'd2608;
      19: r = 30'd1304;
      20: r = 30'd652;
      21: r = 30'd326;
      22: r = 30'd163;
      23: r = 30'd81;
      24: r = 30'd41;
      25: r = 30'd20;
      26: r = 30'd10;
      27: r = 30'd5;
      default: r = 30'd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// File: design/cylindrical_texcoord_gen.sv
// Pipeline: 49 pipeline stages plus the output register; set by the 48-stage
//   quotient pipeline per lane.
// Throughput: one triangle per cycle while out_tready does not stall the output,
//   three vertex lanes in parallel. Reset: synchronous active-low rst_n clears
//   valid bits and loads register defaults (axis z, height 0..1, center 0,0).
`default_nettype none
module cylindrical_texcoord_gen (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // vert0_x, vert0_y, vert0_z, vert1_x, ..., vert2_z (32 bits each)
  input  wire logic [287:0] in_tdata,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // tex0_u, tex0_v, tex1_u, tex1_v, tex2_u, tex2_v (32 bits each)
  output logic [191:0]      out_tdata,
  // span_zero
  output logic [0:0]        out_tuser,
  input  wire logic         cfg_psel,
  input  wire logic         cfg_penable,
  input  wire logic         cfg_pwrite,
  input  wire logic [4:0]   cfg_paddr,
  input  wire logic [31:0]  cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);
  import ctc_pkg::*;

  logic [1:0]                axis_r;
  logic signed [COORD_W-1:0] hmin_r, hmax_r, cfirst_r, csecnd_r;

  assign cfg_pready = 1'b1;

  logic       cfg_wr;
  logic [2:0] cfg_idx;
  assign cfg_wr  = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx = cfg_paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      axis_r   <= AXIS_Z;
      hmin_r   <= '0;
      hmax_r   <= 32'sd65536;
      cfirst_r <= '0;
      csecnd_r <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_AXIS:   axis_r   <= cfg_pwdata[1:0];
        REG_HMIN:   hmin_r   <= cfg_pwdata;
        REG_HMAX:   hmax_r   <= cfg_pwdata;
        REG_CFIRST: cfirst_r <= cfg_pwdata;
        REG_CSECND: csecnd_r <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_AXIS:   cfg_prdata = {30'd0, axis_r};
      REG_HMIN:   cfg_prdata = hmin_r;
      REG_HMAX:   cfg_prdata = hmax_r;
      REG_CFIRST: cfg_prdata = cfirst_r;
      REG_CSECND: cfg_prdata = csecnd_r;
      default:    cfg_prdata = '0;
    endcase
  end

  logic signed [DIFF_W-1:0] span;
  logic                     span_zero;
  ctc_div_cfg_t             dcfg;

  always_comb begin
    span          = DIFF_W'(hmax_r) - DIFF_W'(hmin_r);
    span_zero     = (hmax_r == hmin_r);
    dcfg.hmin     = hmin_r;
    dcfg.span_neg = span[DIFF_W-1];
    dcfg.span_mag = span[DIFF_W-1] ? COORD_W'(DIFF_W'(0) - span) : span[COORD_W-1:0];
  end

  logic [PIPE_DEPTH-1:0] vld_r;
  logic                  out_valid_r;
  logic                  adv, out_load;

  assign out_load  = !out_valid_r || out_tready;
  assign adv       = !vld_r[PIPE_DEPTH-1] || out_load;
  assign in_tready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv) vld_r <= {vld_r[PIPE_DEPTH-2:0], in_tvalid};
      if (out_load) out_valid_r <= vld_r[PIPE_DEPTH-1];
    end
  end

  logic [COORD_W-1:0]        lane_u [0:LANES-1];
  logic signed [COORD_W-1:0] lane_v [0:LANES-1];

  for (genvar k = 0; k < LANES; k++) begin : g_lane
    logic signed [COORD_W-1:0] vx, vy, vz, sa, sb, sh;
    assign vx = in_tdata[VERT_W*k +: COORD_W];
    assign vy = in_tdata[VERT_W*k + COORD_W +: COORD_W];
    assign vz = in_tdata[VERT_W*k + 2*COORD_W +: COORD_W];
    always_comb begin
      case (axis_r)
        AXIS_X: begin sa = vy; sb = vz; sh = vx; end
        AXIS_Y: begin sa = vz; sb = vx; sh = vy; end
        default: begin sa = vx; sb = vy; sh = vz; end
      endcase
    end
    ctc_angle u_angle (
      .clk(clk), .adv(adv), .a_in(sa), .b_in(sb),
      .center_a(cfirst_r), .center_b(csecnd_r), .u_out(lane_u[k])
    );
    ctc_div u_div (
      .clk(clk), .adv(adv), .h_in(sh), .cfg(dcfg), .q_out(lane_v[k])
    );
  end

  // merge: seam fix against vertex 0
  function automatic logic [COORD_W-1:0] seam(input logic [COORD_W-1:0] u,
                                              input logic [COORD_W-1:0] u0);
    logic signed [DIFF_W-1:0] d;
    logic signed [DIFF_W-1:0] us;
    d  = DIFF_W'($signed(u)) - DIFF_W'($signed(u0));
    us = DIFF_W'($signed(u));
    if (d > U_HALF) return COORD_W'(us - U_ONE);
    if (d < -U_HALF) return COORD_W'(us + U_ONE);
    return u;
  endfunction

  logic [191:0] out_data_r, out_data_nxt;
  logic         out_sz_r, out_sz_nxt;

  always_comb begin
    out_data_nxt = {
      span_zero ? 32'd0 : lane_v[2], seam(lane_u[2], lane_u[0]),
      span_zero ? 32'd0 : lane_v[1], seam(lane_u[1], lane_u[0]),
      span_zero ? 32'd0 : lane_v[0], lane_u[0]
    };
    out_sz_nxt = span_zero;
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= out_data_nxt;
      out_sz_r   <= out_sz_nxt;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;
  assign out_tuser[0] = out_sz_r;

  a_span_zero_v: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |->
      out_tdata[63:32] == '0 && out_tdata[127:96] == '0 && out_tdata[191:160] == '0)
    else $error("v not zero on empty span");

  a_u0_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[31:0] <= 32'(U_ONE))
    else $error("u0 out of range");

  a_seam1: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |->
      ($signed(DIFF_W'($signed(out_tdata[95:64])) - DIFF_W'($signed(out_tdata[31:0])))
        <= U_HALF) &&
      ($signed(DIFF_W'($signed(out_tdata[95:64])) - DIFF_W'($signed(out_tdata[31:0])))
        >= -U_HALF))
    else $error("seam fix failed on vertex 1");

  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !vld_r[PIPE_DEPTH-1] |-> in_tready)
    else $error("input stalled with empty pipeline tail");

endmodule
`default_nettype wire

// File: design/ctc_angle.sv
`default_nettype none
module ctc_angle (
  input  wire logic                               clk,
  input  wire logic                               adv,
  input  wire logic signed [ctc_pkg::COORD_W-1:0] a_in,
  input  wire logic signed [ctc_pkg::COORD_W-1:0] b_in,
  input  wire logic signed [ctc_pkg::COORD_W-1:0] center_a,
  input  wire logic signed [ctc_pkg::COORD_W-1:0] center_b,
  output logic [ctc_pkg::COORD_W-1:0]             u_out
);
  import ctc_pkg::*;

  logic signed [ANG_XW-1:0]  n_x_r  [0:NORM_STAGES];
  logic signed [ANG_XW-1:0]  n_y_r  [0:NORM_STAGES];
  logic [NORM_TOP-1:0]       n_m_r  [0:NORM_STAGES];
  logic signed [THETA_W-1:0] n_th_r [0:NORM_STAGES];
  logic                      n_byp_r [0:NORM_STAGES];

  logic signed [ANG_XW-1:0]  c_x_r  [0:CORDIC_STEPS-1];
  logic signed [ANG_XW-1:0]  c_y_r  [0:CORDIC_STEPS-1];
  logic signed [THETA_W-1:0] c_th_r [0:CORDIC_STEPS-1];
  logic                      c_byp_r [0:CORDIC_STEPS-1];

  logic [COORD_W-1:0] d_r [0:ANG_DELAY-1];

  // front end: center, exact axis cases, quadrant fold
  logic signed [DIFF_W-1:0]  pa, pb;
  logic signed [DIFF_W:0]    px, py;
  logic [DIFF_W:0]           pay;
  logic signed [THETA_W-1:0] pth;
  logic                      pbyp;

  always_comb begin
    pa   = DIFF_W'(a_in) - DIFF_W'(center_a);
    pb   = DIFF_W'(b_in) - DIFF_W'(center_b);
    pbyp = (pb == '0) || (pa == '0);
    px   = (DIFF_W+1)'(pa);
    py   = (DIFF_W+1)'(pb);
    pth  = '0;
    if (pb == '0) begin
      pth = pa[DIFF_W-1] ? TURN_HALF : '0;
    end else if (pa == '0) begin
      pth = pb[DIFF_W-1] ? -TURN_QUARTER : TURN_QUARTER;
    end else if (pa[DIFF_W-1]) begin
      if (!pb[DIFF_W-1]) begin
        px  = (DIFF_W+1)'(pb);
        py  = -(DIFF_W+1)'(pa);
        pth = TURN_QUARTER;
      end else begin
        px  = -(DIFF_W+1)'(pb);
        py  = (DIFF_W+1)'(pa);
        pth = -TURN_QUARTER;
      end
    end
    pay = py[DIFF_W] ? DIFF_W'(1) + ~py : py;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      n_x_r[0]   <= ANG_XW'(px);
      n_y_r[0]   <= ANG_XW'(py);
      n_m_r[0]   <= (px > $signed(pay)) ? NORM_TOP'(px) : NORM_TOP'(pay);
      n_th_r[0]  <= pth;
      n_byp_r[0] <= pbyp;
    end
  end

  // normalize: two binary shift steps per stage
  for (genvar s = 0; s < NORM_STAGES; s++) begin : g_norm
    localparam int K1 = 32 >> (2 * s);
    localparam int K2 = K1 >> 1;
    logic signed [ANG_XW-1:0] x1, y1, x2, y2;
    logic [NORM_TOP-1:0]      m1, m2;
    always_comb begin
      x1 = n_x_r[s];
      y1 = n_y_r[s];
      m1 = n_m_r[s];
      if ((n_m_r[s] >> (NORM_TOP - K1)) == '0) begin
        x1 = n_x_r[s] <<< K1;
        y1 = n_y_r[s] <<< K1;
        m1 = n_m_r[s] << K1;
      end
      x2 = x1;
      y2 = y1;
      m2 = m1;
      if ((m1 >> (NORM_TOP - K2)) == '0) begin
        x2 = x1 <<< K2;
        y2 = y1 <<< K2;
        m2 = m1 << K2;
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        n_x_r[s+1]   <= x2;
        n_y_r[s+1]   <= y2;
        n_m_r[s+1]   <= m2;
        n_th_r[s+1]  <= n_th_r[s];
        n_byp_r[s+1] <= n_byp_r[s];
      end
    end
  end

  // vectoring rotations
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    logic signed [ANG_XW-1:0]  sx, sy;
    logic signed [THETA_W-1:0] sth;
    logic                      sbyp;
    logic signed [THETA_W-1:0] at;
    if (i == 0) begin : g_src0
      assign sx   = n_x_r[NORM_STAGES];
      assign sy   = n_y_r[NORM_STAGES];
      assign sth  = n_th_r[NORM_STAGES];
      assign sbyp = n_byp_r[NORM_STAGES];
    end else begin : g_srcn
      assign sx   = c_x_r[i-1];
      assign sy   = c_y_r[i-1];
      assign sth  = c_th_r[i-1];
      assign sbyp = c_byp_r[i-1];
    end
    assign at = THETA_W'(atan_turn(i));
    always_ff @(posedge clk) begin
      if (adv) begin
        c_byp_r[i] <= sbyp;
        if (sy > 0) begin
          c_x_r[i]  <= sx + (sy >>> i);
          c_y_r[i]  <= sy - (sx >>> i);
          c_th_r[i] <= sbyp ? sth : sth + at;
        end else begin
          c_x_r[i]  <= sx - (sy >>> i);
          c_y_r[i]  <= sy + (sx >>> i);
          c_th_r[i] <= sbyp ? sth : sth - at;
        end
      end
    end
  end

  // half turn offset, clamp, round to output format
  logic signed [THETA_W:0] tsum;
  logic [THETA_W-2:0]      tcl;
  logic [THETA_W-1:0]      trnd;
  logic [COORD_W-1:0]      u_fin;

  always_comb begin
    tsum = (THETA_W+1)'(c_th_r[CORDIC_STEPS-1]) + (THETA_W+1)'(TURN_HALF);
    if (tsum < 0) tcl = '0;
    else if (tsum > TURN_FULL) tcl = (THETA_W-1)'(TURN_FULL);
    else tcl = tsum[THETA_W-2:0];
    trnd  = THETA_W'(tcl) + (THETA_W'(1) << (31 - FRAC_BITS));
    u_fin = COORD_W'(trnd >> (32 - FRAC_BITS));
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_r[0] <= u_fin;
      for (int j = 1; j < ANG_DELAY; j++) d_r[j] <= d_r[j-1];
    end
  end

  assign u_out = d_r[ANG_DELAY-1];

endmodule
`default_nettype wire

// File: design/ctc_div.sv
`default_nettype none
module ctc_div (
  input  wire logic                               clk,
  input  wire logic                               adv,
  input  wire logic signed [ctc_pkg::COORD_W-1:0] h_in,
  input  wire ctc_pkg::ctc_div_cfg_t              cfg,
  output logic signed [ctc_pkg::COORD_W-1:0]      q_out
);
  import ctc_pkg::*;

  logic [COORD_W-1:0]   dv_rem_r [0:DIV_NUM_W];
  logic [DIV_NUM_W-1:0] dv_nq_r  [0:DIV_NUM_W];
  logic                 dv_neg_r [0:DIV_NUM_W];

  logic signed [DIFF_W-1:0] diff;
  logic [DIFF_W-1:0]        mag;

  always_comb begin
    diff = DIFF_W'(h_in) - DIFF_W'(cfg.hmin);
    mag  = diff[DIFF_W-1] ? DIFF_W'(0) - diff : diff;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_rem_r[0] <= '0;
      dv_nq_r[0]  <= {mag[COORD_W-1:0], {FRAC_BITS{1'b0}}};
      dv_neg_r[0] <= diff[DIFF_W-1] ^ cfg.span_neg;
    end
  end

  // restoring division, one quotient bit per stage
  for (genvar j = 1; j <= DIV_NUM_W; j++) begin : g_step
    logic [COORD_W:0] r;
    logic             ge;
    always_comb begin
      r  = {dv_rem_r[j-1], dv_nq_r[j-1][DIV_NUM_W-1]};
      ge = r >= {1'b0, cfg.span_mag};
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        dv_rem_r[j] <= ge ? COORD_W'(r - {1'b0, cfg.span_mag}) : r[COORD_W-1:0];
        dv_nq_r[j]  <= {dv_nq_r[j-1][DIV_NUM_W-2:0], ge};
        dv_neg_r[j] <= dv_neg_r[j-1];
      end
    end
  end

  logic [DIV_NUM_W-1:0] qm;

  always_comb begin
    qm = dv_nq_r[DIV_NUM_W];
    if (!dv_neg_r[DIV_NUM_W]) begin
      if (qm > DIV_NUM_W'(32'h7FFF_FFFF)) q_out = 32'sh7FFF_FFFF;
      else q_out = qm[COORD_W-1:0];
    end else begin
      if (qm > DIV_NUM_W'(32'h8000_0000)) q_out = 32'sh8000_0000;
      else q_out = COORD_W'(0) - qm[COORD_W-1:0];
    end
  end

endmodule
`default_nettype wire

// File: test/tb_cylindrical_texcoord_gen.sv
`default_nettype none
module tb_cylindrical_texcoord_gen;
  import ctc_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 80;
  localparam int RANDOM_PER_SET = 190;

  localparam longint ATAN_TURNS [28] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10, 5
  };

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [287:0] in_tdata;
  logic         out_tvalid;
  logic         out_tready;
  logic [191:0] out_tdata;
  logic [0:0]   out_tuser;
  logic         cfg_psel;
  logic         cfg_penable;
  logic         cfg_pwrite;
  logic [4:0]   cfg_paddr;
  logic [31:0]  cfg_pwdata;
  logic [31:0]  cfg_prdata;
  logic         cfg_pready;

  cylindrical_texcoord_gen u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  // shadow of the block's registers
  logic [1:0]         axis_sh;
  logic signed [31:0] hmin_sh, hmax_sh, cfirst_sh, csecnd_sh;

  logic [287:0] tri_pending[$];
  logic [192:0] texcoord_due[$];

  int  snd_idle_pct, rcv_stall_pct;
  bit  long_hold_req, long_hold_done;
  int  hold_cnt;
  bit  in_took;
  int  mismatches;
  int  quiet_cycles;

  always begin
    clk = 1'b1; #2;
    clk = 1'b0; #2;
  end

  function automatic longint wrapped_turn(longint a, longint b);
    longint theta, x, y, m, t, dx, dy;
    if (b == 0) begin
      theta = (a >= 0) ? 0 : 64'sd2147483648;
    end else if (a == 0) begin
      theta = (b > 0) ? 64'sd1073741824 : -64'sd1073741824;
    end else begin
      x = a; y = b; theta = 0;
      if (x < 0) begin
        if (y > 0) begin
          t = x; x = y; y = -t; theta = 64'sd1073741824;
        end else begin
          t = x; x = -y; y = t; theta = -64'sd1073741824;
        end
      end
      m = (y < 0) ? -y : y;
      if (x > m) m = x;
      while (m < (64'sd1 << 40)) begin
        x = x * 2; y = y * 2; m = m * 2;
      end
      for (int i = 0; i < 28; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (y > 0) begin
          x = x + dx; y = y - dy; theta = theta + ATAN_TURNS[i];
        end else begin
          x = x - dx; y = y + dy; theta = theta - ATAN_TURNS[i];
        end
      end
    end
    t = theta + 64'sd2147483648;
    if (t < 0) t = 0;
    if (t > 64'sd4294967296) t = 64'sd4294967296;
    return (t + (64'sd1 << 15)) >>> 16;
  endfunction

  function automatic logic [192:0] texcoords_of(logic [287:0] d);
    longint u[3], v[3], px, py, pz, a, b, h, span, q, diff;
    logic [192:0] r;
    span = longint'(hmax_sh) - longint'(hmin_sh);
    for (int k = 0; k < 3; k++) begin
      px = longint'($signed(d[96*k +: 32]));
      py = longint'($signed(d[96*k+32 +: 32]));
      pz = longint'($signed(d[96*k+64 +: 32]));
      case (axis_sh)
        AXIS_X: begin a = py; b = pz; h = px; end
        AXIS_Y: begin a = pz; b = px; h = py; end
        default: begin a = px; b = py; h = pz; end
      endcase
      u[k] = wrapped_turn(a - longint'(cfirst_sh), b - longint'(csecnd_sh));
      if (span == 0) begin
        v[k] = 0;
      end else begin
        q = ((h - longint'(hmin_sh)) * 65536) / span;
        if (q > 64'sd2147483647) q = 64'sd2147483647;
        if (q < -64'sd2147483648) q = -64'sd2147483648;
        v[k] = q;
      end
    end
    for (int k = 1; k < 3; k++) begin
      diff = u[k] - u[0];
      if (diff > 32768) u[k] = u[k] - 65536;
      else if (diff < -32768) u[k] = u[k] + 65536;
    end
    for (int k = 0; k < 3; k++) begin
      r[64*k +: 32]    = u[k][31:0];
      r[64*k+32 +: 32] = v[k][31:0];
    end
    r[192] = (span == 0);
    return r;
  endfunction

  // input acceptance and output check at the rising edge
  always @(posedge clk) begin
    in_took = 1'b0;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        in_took = 1'b1;
        texcoord_due = {texcoord_due, texcoords_of(in_tdata)};
        void'(tri_pending.pop_front());
      end
      if (out_tvalid && out_tready) begin
        if (texcoord_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected transaction: %h", out_tdata);
        end else begin
          logic [192:0] want;
          want = texcoord_due.pop_front();
          for (int f = 0; f < 7; f++) begin
            logic [31:0] got_f, want_f;
            got_f  = (f == 6) ? {31'd0, out_tuser[0]} : out_tdata[32*f +: 32];
            want_f = (f == 6) ? {31'd0, want[192]} : want[32*f +: 32];
            if (got_f !== want_f) begin
              mismatches++;
              if (mismatches <= 10)
                $display("field %0d mismatch: expected %h actual %h", f, want_f, got_f);
            end
          end
        end
      end
    end
  end

  // sender
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!(in_tvalid && !in_took)) begin
      if (tri_pending.size() > 0 && $urandom_range(99) >= snd_idle_pct) begin
        in_tvalid <= 1'b1;
        in_tdata  <= tri_pending[0];
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // receiver, with one long hold-off on request
  always @(negedge clk) begin
    if (long_hold_req && !long_hold_done) begin
      long_hold_done = 1'b1;
      hold_cnt = 400;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= rcv_stall_pct);
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (tri_pending.size() == 0 && texcoord_due.size() == 0))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic reg_write(logic [2:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= val;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    case (idx)
      REG_AXIS:   axis_sh   = val[1:0];
      REG_HMIN:   hmin_sh   = val;
      REG_HMAX:   hmax_sh   = val;
      REG_CFIRST: cfirst_sh = val;
      default:    csecnd_sh = val;
    endcase
  endtask

  task automatic settle();
    while (tri_pending.size() > 0 || texcoord_due.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_regs(logic [1:0] ax, logic [31:0] lo, logic [31:0] hi,
                          logic [31:0] c1, logic [31:0] c2);
    settle();
    reg_write(REG_AXIS, {30'd0, ax});
    reg_write(REG_HMIN, lo);
    reg_write(REG_HMAX, hi);
    reg_write(REG_CFIRST, c1);
    reg_write(REG_CSECND, c2);
  endtask

  function automatic logic [31:0] rand_coord(logic [31:0] centre);
    case ($urandom_range(5))
      0, 1: return $urandom;
      2:    return centre + $urandom_range(32'h0004_0000) - 32'h0002_0000;
      3:    return centre;
      4:    return $urandom_range(32'h0008_0000) - 32'h0004_0000;
      default: return ($urandom_range(1)) ? 32'h7FFF_FFFF : 32'h8000_0000;
    endcase
  endfunction

  task automatic push_tri(logic [31:0] c [9]);
    logic [287:0] d;
    for (int i = 0; i < 9; i++) d[32*i +: 32] = c[i];
    tri_pending = {tri_pending, d};
  endtask

  task automatic push_random(int n);
    logic [31:0] c [9];
    logic [31:0] ca, cb;
    for (int j = 0; j < n; j++) begin
      for (int k = 0; k < 3; k++) begin
        ca = rand_coord(cfirst_sh);
        cb = rand_coord(csecnd_sh);
        case (axis_sh)
          AXIS_X: begin c[3*k+1] = ca; c[3*k+2] = cb; c[3*k] = rand_coord(hmin_sh); end
          AXIS_Y: begin c[3*k+2] = ca; c[3*k] = cb; c[3*k+1] = rand_coord(hmin_sh); end
          default: begin c[3*k] = ca; c[3*k+1] = cb; c[3*k+2] = rand_coord(hmin_sh); end
        endcase
      end
      push_tri(c);
    end
  endtask

  task automatic run_phase(int idle, int stall, int n);
    snd_idle_pct  = idle;
    rcv_stall_pct = stall;
    push_random(n);
  endtask

  initial begin
    logic [31:0] c [9];
    rst_n = 1'b0;
    in_tvalid = 1'b0; in_tdata = '0; out_tready = 1'b0;
    cfg_psel = 1'b0; cfg_penable = 1'b0; cfg_pwrite = 1'b0;
    cfg_paddr = '0; cfg_pwdata = '0;
    axis_sh = AXIS_Z; hmin_sh = 0; hmax_sh = 32'd65536; cfirst_sh = 0; csecnd_sh = 0;
    snd_idle_pct = 0; rcv_stall_pct = 0;
    long_hold_req = 0; long_hold_done = 0; hold_cnt = 0;
    mismatches = 0; quiet_cycles = 0; in_took = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: axis cases, extremes, seam wrap, at reset settings
    c = '{0, 0, 0, 32'h10000, 0, 32'h10000, 32'hFFFF0000, 0, 32'h8000};
    push_tri(c);
    c = '{0, 32'h10000, 0, 0, 32'hFFFF0000, 0, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'h7FFF_FFFF};
    push_tri(c);
    c = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
          32'h8000_0000, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF};
    push_tri(c);
    // seam: vertex 0 just above the negative x axis, others just below
    c = '{32'hFFFF0000, 32'h1, 0, 32'hFFFF0000, 32'hFFFFFFFF, 0,
          32'hFFFF0000, 32'hFFFFFF00, 32'h10000};
    push_tri(c);
    c = '{32'hFFFF0000, 32'hFFFFFFFF, 0, 32'hFFFF0000, 32'h1, 0,
          32'h8000_0000, 32'h1, 32'h8000_0000};
    push_tri(c);
    c = '{1, 1, 1, 32'hFFFFFFFF, 1, 2, 1, 32'hFFFFFFFF, 3};
    push_tri(c);
    push_random(4);
    // empty span
    set_regs(AXIS_X, 32'h1234, 32'h1234, 0, 0);
    push_random(5);
    // widest span and reversed widest span
    set_regs(AXIS_Y, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
    push_random(4);
    set_regs(AXIS_Z, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
    push_random(4);
    // tiny span saturates v
    set_regs(AXIS_X, 32'h8000_0000, 32'h8000_0001, 0, 0);
    push_random(4);

    set_regs(AXIS_Z, 0, 32'h10000, 0, 0);
    run_phase(0, 0, RANDOM_PER_SET);
    set_regs(AXIS_X, $urandom, $urandom, $urandom, $urandom);
    run_phase(71, 0, RANDOM_PER_SET);
    set_regs(AXIS_Y, 32'hFFFE_0000, 32'h0003_0000, 32'h0000_8000, 32'hFFFF_4000);
    run_phase(0, 71, RANDOM_PER_SET);
    set_regs(AXIS_Z, 32'h5555, 32'h5555, 32'h7FFF_FFFF, 32'h8000_0000);
    run_phase(11, 11, RANDOM_PER_SET);
    set_regs(AXIS_X, 32'h0001_0000, 32'hFFFF_0000, 32'h8000_0000, 32'h7FFF_FFFF);
    long_hold_req = 1'b1;
    run_phase(0, 0, RANDOM_PER_SET);
    set_regs(AXIS_Y, $urandom, $urandom, $urandom, $urandom);
    run_phase(71, 71, RANDOM_PER_SET);
    set_regs(2'd0, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0);
    run_phase(0, 0, RANDOM_PER_SET);
    set_regs(AXIS_Z, $urandom, $urandom, $urandom, $urandom);
    run_phase(11, 71, RANDOM_PER_SET);

    settle();
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire
